// File: sv/sha1_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and controller/datapath link types for the SHA-1 engine.
package sha1_pkg;

	localparam int WORD_W = 32;
	localparam int HASH_WORDS = 5;

	// SHA-1 initial vector, most significant word first
	localparam logic [WORD_W-1:0] INIT_VECTOR [HASH_WORDS] = '{
		32'h6745_2301, 32'hEFCD_AB89, 32'h98BA_DCFE, 32'h1032_5476, 32'hC3D2_E1F0
	};

	// Round constants, one per group of twenty rounds
	localparam logic [WORD_W-1:0] ROUND_K [4] = '{
		32'h5A82_7999, 32'h6ED9_EBA1, 32'h8F1B_BCDC, 32'hCA62_C1D6
	};

	localparam logic [7:0] PAD_MARK = 8'h80;

	// Source of a word pushed into the block buffer
	localparam logic [2:0] PUSH_DATA  = 3'd0;
	localparam logic [2:0] PUSH_TAIL  = 3'd1;
	localparam logic [2:0] PUSH_ZERO  = 3'd2;
	localparam logic [2:0] PUSH_LENHI = 3'd3;
	localparam logic [2:0] PUSH_LENLO = 3'd4;

	// Round function groups
	localparam logic [1:0] FN_CHOOSE = 2'd0;
	localparam logic [1:0] FN_PARITY = 2'd1;
	localparam logic [1:0] FN_MAJ    = 2'd2;
	localparam logic [1:0] FN_PAR2   = 2'd3;

	typedef struct packed {
		logic       push;        // shift one word into the block buffer
		logic [2:0] push_sel;    // which word to shift in
		logic       load;        // copy hash words into the working registers
		logic       round;       // run one compression round
		logic [1:0] fsel;        // round function group
		logic       fold;        // add working registers into the hash words
		logic       capture;     // final word: add its bits, build the tail word
		logic       count_word;  // add 32 bits to the length
		logic       restart;     // back to the initial vector, length zero
		logic [2:0] out_idx;     // digest word on the output
	} sha1_cmd_t;

	typedef struct packed {
		logic [3:0] pos;         // next free slot in the block buffer
	} sha1_sts_t;

endpackage

// File: sv/sha1_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the SHA-1 engine: intake, padding, round count and digest output.
module sha1_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_last,
	input  logic                  in_full,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  out_last,
	output sha1_pkg::sha1_cmd_t   cmd,
	input  sha1_pkg::sha1_sts_t   sts
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_TAIL  = 3'd1;
	localparam logic [2:0] ST_ZERO  = 3'd2;
	localparam logic [2:0] ST_LENLO = 3'd3;
	localparam logic [2:0] ST_ROUND = 3'd4;
	localparam logic [2:0] ST_FOLD  = 3'd5;
	localparam logic [2:0] ST_EMIT  = 3'd6;

	localparam logic [6:0] LAST_ROUND = 7'd79;
	localparam logic [3:0] POS_LAST   = 4'd15;
	localparam logic [3:0] POS_LEN    = 4'd14;
	localparam logic [2:0] IDX_LAST   = 3'(sha1_pkg::HASH_WORDS - 1);

	logic [2:0] st_q, st_d;
	logic [2:0] res_q, res_d;
	logic [6:0] rnd_q, rnd_d;
	logic [2:0] idx_q, idx_d;

	assign in_ready  = (st_q == ST_IDLE);
	assign out_valid = (st_q == ST_EMIT);
	assign out_last  = (idx_q == IDX_LAST);

	always_comb begin
		cmd         = '0;
		cmd.out_idx = idx_q;
		st_d        = st_q;
		res_d       = res_q;
		rnd_d       = rnd_q;
		idx_d       = idx_q;

		priority if (rnd_q < 7'd20) begin
			cmd.fsel = sha1_pkg::FN_CHOOSE;
		end else if (rnd_q < 7'd40) begin
			cmd.fsel = sha1_pkg::FN_PARITY;
		end else if (rnd_q < 7'd60) begin
			cmd.fsel = sha1_pkg::FN_MAJ;
		end else begin
			cmd.fsel = sha1_pkg::FN_PAR2;
		end

		unique case (st_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (!in_last) begin
						cmd.push       = 1'b1;
						cmd.push_sel   = sha1_pkg::PUSH_DATA;
						cmd.count_word = 1'b1;
						if (sts.pos == POS_LAST) begin
							cmd.load = 1'b1;
							res_d    = ST_IDLE;
							st_d     = ST_ROUND;
						end
					end else begin
						cmd.capture = 1'b1;
						st_d        = ST_TAIL;
						if (in_full) begin
							cmd.push     = 1'b1;
							cmd.push_sel = sha1_pkg::PUSH_DATA;
							if (sts.pos == POS_LAST) begin
								cmd.load = 1'b1;
								res_d    = ST_TAIL;
								st_d     = ST_ROUND;
							end
						end
					end
				end
			end
			ST_TAIL: begin
				cmd.push     = 1'b1;
				cmd.push_sel = sha1_pkg::PUSH_TAIL;
				st_d         = ST_ZERO;
				if (sts.pos == POS_LAST) begin
					cmd.load = 1'b1;
					res_d    = ST_ZERO;
					st_d     = ST_ROUND;
				end
			end
			ST_ZERO: begin
				cmd.push = 1'b1;
				if (sts.pos == POS_LEN) begin
					cmd.push_sel = sha1_pkg::PUSH_LENHI;
					st_d         = ST_LENLO;
				end else begin
					cmd.push_sel = sha1_pkg::PUSH_ZERO;
					if (sts.pos == POS_LAST) begin
						cmd.load = 1'b1;
						res_d    = ST_ZERO;
						st_d     = ST_ROUND;
					end
				end
			end
			ST_LENLO: begin
				cmd.push     = 1'b1;
				cmd.push_sel = sha1_pkg::PUSH_LENLO;
				cmd.load     = 1'b1;
				res_d        = ST_EMIT;
				st_d         = ST_ROUND;
			end
			ST_ROUND: begin
				cmd.round = 1'b1;
				if (rnd_q == LAST_ROUND) begin
					rnd_d = '0;
					st_d  = ST_FOLD;
				end else begin
					rnd_d = rnd_q + 7'd1;
				end
			end
			ST_FOLD: begin
				cmd.fold = 1'b1;
				st_d     = res_q;
			end
			ST_EMIT: begin
				if (out_ready) begin
					if (idx_q == IDX_LAST) begin
						idx_d       = '0;
						cmd.restart = 1'b1;
						st_d        = ST_IDLE;
					end else begin
						idx_d = idx_q + 3'd1;
					end
				end
			end
			default: begin
				st_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= ST_IDLE;
			res_q <= ST_IDLE;
			rnd_q <= '0;
			idx_q <= '0;
		end else begin
			st_q  <= st_d;
			res_q <= res_d;
			rnd_q <= rnd_d;
			idx_q <= idx_d;
		end
	end

endmodule

// File: sv/sha1_dp.sv
`timescale 1ns / 1ps
// SHA-1 datapath: block window, message schedule, round logic, hash words and bit length.
module sha1_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sha1_pkg::sha1_cmd_t  cmd,
	output sha1_pkg::sha1_sts_t  sts,
	input  logic [31:0]          in_word,
	input  logic [2:0]           in_bytes,
	output logic [31:0]          digest
);

	logic [31:0] win_q [16];
	logic [31:0] hash_q [sha1_pkg::HASH_WORDS];
	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [63:0] len_q;
	logic [3:0]  pos_q;
	logic [31:0] tail_q;

	logic [2:0]  nbytes;
	logic [31:0] tail_d;
	logic [31:0] push_word;
	logic [31:0] sched_x, sched_w;
	logic [31:0] fval;
	logic [31:0] tmp;

	assign sts.pos = pos_q;
	assign digest  = hash_q[cmd.out_idx];

	// counts above four saturate
	assign nbytes = in_bytes[2] ? 3'd4 : in_bytes;

	always_comb begin
		unique case (nbytes)
			3'd1:    tail_d = {in_word[31:24], sha1_pkg::PAD_MARK, 16'd0};
			3'd2:    tail_d = {in_word[31:16], sha1_pkg::PAD_MARK, 8'd0};
			3'd3:    tail_d = {in_word[31:8], sha1_pkg::PAD_MARK};
			default: tail_d = {sha1_pkg::PAD_MARK, 24'd0};
		endcase
	end

	always_comb begin
		unique case (cmd.push_sel)
			sha1_pkg::PUSH_DATA:  push_word = in_word;
			sha1_pkg::PUSH_TAIL:  push_word = tail_q;
			sha1_pkg::PUSH_LENHI: push_word = len_q[63:32];
			sha1_pkg::PUSH_LENLO: push_word = len_q[31:0];
			default:              push_word = '0;
		endcase
	end

	// window holds w[t..t+15]; the next schedule word is w[t+16]
	assign sched_x = win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0];
	assign sched_w = {sched_x[30:0], sched_x[31]};

	always_comb begin
		unique case (cmd.fsel)
			sha1_pkg::FN_CHOOSE: fval = (b_q & c_q) | (~b_q & d_q);
			sha1_pkg::FN_MAJ:    fval = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			default:             fval = b_q ^ c_q ^ d_q;
		endcase
	end

	assign tmp = {a_q[26:0], a_q[31:27]} + fval + e_q + sha1_pkg::ROUND_K[cmd.fsel] + win_q[0];

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			for (int i = 0; i < 15; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[15] <= push_word;
		end else if (cmd.round) begin
			for (int i = 0; i < 15; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[15] <= sched_w;
		end
		if (cmd.capture) begin
			tail_q <= tail_d;
		end
		if (cmd.load) begin
			a_q <= hash_q[0];
			b_q <= hash_q[1];
			c_q <= hash_q[2];
			d_q <= hash_q[3];
			e_q <= hash_q[4];
		end else if (cmd.round) begin
			a_q <= tmp;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < sha1_pkg::HASH_WORDS; i++) begin
				hash_q[i] <= sha1_pkg::INIT_VECTOR[i];
			end
			len_q <= '0;
			pos_q <= '0;
		end else begin
			if (cmd.restart) begin
				for (int i = 0; i < sha1_pkg::HASH_WORDS; i++) begin
					hash_q[i] <= sha1_pkg::INIT_VECTOR[i];
				end
				len_q <= '0;
			end else begin
				if (cmd.fold) begin
					hash_q[0] <= hash_q[0] + a_q;
					hash_q[1] <= hash_q[1] + b_q;
					hash_q[2] <= hash_q[2] + c_q;
					hash_q[3] <= hash_q[3] + d_q;
					hash_q[4] <= hash_q[4] + e_q;
				end
				if (cmd.count_word) begin
					len_q <= len_q + 64'd32;
				end else if (cmd.capture) begin
					len_q <= len_q + {58'd0, nbytes, 3'd0};
				end
			end
			if (cmd.push) begin
				pos_q <= pos_q + 4'd1;
			end
		end
	end

endmodule

// File: sv/sha1_message_digest.sv
`timescale 1ns / 1ps
// Top level of the SHA-1 message digest engine.
// Intake: one word per cycle while idle; the sixteenth word of a block starts the round
// unit, which runs 80 rounds and then a fold step before intake resumes.
// After a final word: tail, zero and length padding words, one or two compressions,
// then five digest items, one per cycle while m_tready is high.
// Reset (arst_n low, asynchronous): idle, initial vector loaded, length and position zero.
module sha1_message_digest (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [31:0] data_word, [34:32] valid_bytes, [39:35] zero
	input  logic        s_tlast,   // final_word
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, [39:35] zero
	output logic        m_tlast    // last_word
);

	sha1_pkg::sha1_cmd_t cmd;
	sha1_pkg::sha1_sts_t sts;
	logic [31:0]         digest;

	// Besides the buffer position from the datapath, the controller sees only handshakes,
	// the last-item flag and whether the final word carries a full four bytes (any count of four or more).
	sha1_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_last   (s_tlast),
		.in_full   (s_tdata[34]),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_last  (m_tlast),
		.cmd       (cmd),
		.sts       (sts)
	);

	// Datapath holds the 16-word window, working registers, hash words and length.
	sha1_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.in_word  (s_tdata[31:0]),
		.in_bytes (s_tdata[34:32]),
		.digest   (digest)
	);

	// Digest words come straight from the hash registers, stable while stalled.
	assign m_tdata = {5'd0, cmd.out_idx, digest};

endmodule

// File: sv/sha1_chk.sv
`timescale 1ns / 1ps
// Port-level checker for the SHA-1 engine, bound to the top level.
module sha1_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic        m_tlast
);

	// output item holds while stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
	else $error("output item changed while stalled");

	// intake and digest output never overlap
	assert property (@(posedge clk) disable iff (!arst_n) !(s_tready && m_tvalid))
	else $error("input ready during digest output");

	// last flag only on the fifth digest word
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (m_tdata[34:32] == 3'd4)))
	else $error("last flag and word index disagree");

	// digest words advance one index at a time
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=>
			m_tvalid && (m_tdata[34:32] == 3'($past(m_tdata[34:32]) + 3'd1)))
	else $error("digest word index did not advance");

	// engine is ready for a new message right after the last digest word
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast |=> s_tready)
	else $error("not ready after digest");

endmodule

bind sha1_message_digest sha1_chk u_sha1_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
